>>> hdl/fwp_pkg.sv
// ----------------------------------------------------------------------------
// fwp_pkg
// shared types and constants of the four-level page walker
// ----------------------------------------------------------------------------
`default_nettype none

package fwp_pkg;

    // physical address bits actually kept, range 32 to 52
    localparam int PHYS_ADDR_BITS = 52;

    // fixed field widths of the channels
    localparam int ADDR_FIELD_W = 52;
    localparam int VA_W         = 64;
    localparam int ENTRY_W      = 64;
    localparam int VA_HELD_W    = 48;
    localparam int PAGE_OFF_W   = 12;
    localparam int INDEX_W      = 9;
    localparam int FRAME_W      = PHYS_ADDR_BITS - PAGE_OFF_W;
    localparam int LEVEL_W      = 3;

    // index positions of each level in the virtual address
    localparam int IDX_LSB_L4 = 39;
    localparam int IDX_LSB_L3 = 30;
    localparam int IDX_LSB_L2 = 21;
    localparam int IDX_LSB_L1 = 12;

    // entry flag bits
    localparam int BIT_PRESENT = 0;
    localparam int BIT_HUGE    = 7;

    // canonical check covers bits 63..47
    localparam int CANON_LSB = 47;

    // decoupling queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // walk levels
    localparam logic [LEVEL_W-1:0] LEVEL_IDLE = 3'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_ONE  = 3'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_TWO  = 3'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_THREE = 3'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_FOUR = 3'd4;

    typedef enum logic [2:0] {
        KIND_READ     = 3'd0,
        KIND_DONE     = 3'd1,
        KIND_ABSENT   = 3'd2,
        KIND_NONCANON = 3'd3,
        KIND_PROTOCOL = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        SIZE_4K = 2'd0,
        SIZE_2M = 2'd1,
        SIZE_1G = 2'd2
    } page_size_t;

    // classified beat passed from front to back
    typedef struct packed {
        logic                 is_entry;
        logic                 canonical;
        logic [VA_HELD_W-1:0] va_held;
        logic [FRAME_W-1:0]   frame;
        logic                 present;
        logic                 huge;
    } item_t;

endpackage

`default_nettype wire

>>> hdl/fwp_if.sv
// ----------------------------------------------------------------------------
// fwp channel interfaces
// request, response and configuration channels of the page walker
// ----------------------------------------------------------------------------
`default_nettype none

interface fwp_req_if;
    import fwp_pkg::*;

    logic               valid;
    logic               ready;
    logic               mode;
    logic [VA_W-1:0]    virt_addr;
    logic [ENTRY_W-1:0] entry_data;

    modport source (output valid, output mode, output virt_addr, output entry_data,
                    input ready);
    modport sink   (input valid, input mode, input virt_addr, input entry_data,
                    output ready);
endinterface

interface fwp_rsp_if;
    import fwp_pkg::*;

    logic                    valid;
    logic                    ready;
    kind_t                   kind;
    logic [ADDR_FIELD_W-1:0] read_addr;
    logic [ADDR_FIELD_W-1:0] phys_addr;
    page_size_t              page_size;

    modport source (output valid, output kind, output read_addr, output phys_addr,
                    output page_size, input ready);
    modport sink   (input valid, input kind, input read_addr, input phys_addr,
                    input page_size, output ready);
endinterface

interface fwp_cfg_if;
    import fwp_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ADDR_FIELD_W-1:0] table_root;

    modport source (output valid, output table_root, input ready);
    modport sink   (input valid, input table_root, output ready);
endinterface

`default_nettype wire

>>> hdl/fwp_front.sv
// ----------------------------------------------------------------------------
// fwp_front
// accepts request and entry beats and classifies them for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module fwp_front (
    fwp_req_if.sink        req,
    input  wire logic      q_full,
    output fwp_pkg::item_t q_item,
    output logic           q_push
);
    import fwp_pkg::*;

    logic [VA_W-1:CANON_LSB] upper_bits;

    assign upper_bits = req.virt_addr[VA_W-1:CANON_LSB];
    assign req.ready  = ~q_full;
    assign q_push     = req.valid & ~q_full;

    always_comb
    begin
        q_item.is_entry  = req.mode;
        // canonical when bits 63..47 all match
        q_item.canonical = (&upper_bits) | ~(|upper_bits);
        q_item.va_held   = req.virt_addr[VA_HELD_W-1:0];
        q_item.frame     = req.entry_data[PHYS_ADDR_BITS-1:PAGE_OFF_W];
        q_item.present   = req.entry_data[BIT_PRESENT];
        q_item.huge      = req.entry_data[BIT_HUGE];
    end

endmodule

`default_nettype wire

>>> hdl/fwp_queue.sv
// ----------------------------------------------------------------------------
// fwp_queue
// short fifo between front and back ends
// ----------------------------------------------------------------------------
`default_nettype none

module fwp_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire fwp_pkg::item_t  push_item,
    output logic                 full,
    input  wire logic            pop,
    output logic                 not_empty,
    output fwp_pkg::item_t       head_item
);
    import fwp_pkg::*;

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

>>> hdl/fwp_back.sv
// ----------------------------------------------------------------------------
// fwp_back
// walk state, next entry address and final translation, one beat per cycle while rsp is ready
// ----------------------------------------------------------------------------
`default_nettype none

module fwp_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [fwp_pkg::FRAME_W-1:0] root_frame,
    input  wire logic                        q_valid,
    input  wire fwp_pkg::item_t              q_item,
    output logic                             q_pop,
    fwp_rsp_if.source                        rsp
);
    import fwp_pkg::*;

    logic [LEVEL_W-1:0]   level_reg, level_next;
    logic [VA_HELD_W-1:0] held_reg, held_next;

    logic                    out_valid_reg;
    kind_t                   kind_reg, kind_next;
    logic [ADDR_FIELD_W-1:0] raddr_reg, raddr_next;
    logic [ADDR_FIELD_W-1:0] paddr_reg, paddr_next;
    page_size_t              size_reg, size_next;

    logic                      busy;
    logic [FRAME_W-1:0]        base;
    logic [INDEX_W-1:0]        idx;
    logic [PHYS_ADDR_BITS-1:0] entry_pa;
    logic [PHYS_ADDR_BITS-1:0] page_1g, page_2m, page_4k;

    assign q_pop     = q_valid & (~out_valid_reg | rsp.ready);
    assign busy      = (level_reg >= LEVEL_ONE) && (level_reg <= LEVEL_FOUR);
    assign entry_pa  = {base, idx, 3'b000};
    assign page_1g   = {q_item.frame[FRAME_W-1:IDX_LSB_L3-PAGE_OFF_W],
                        held_reg[IDX_LSB_L3-1:0]};
    assign page_2m   = {q_item.frame[FRAME_W-1:IDX_LSB_L2-PAGE_OFF_W],
                        held_reg[IDX_LSB_L2-1:0]};
    assign page_4k   = {q_item.frame, held_reg[PAGE_OFF_W-1:0]};

    assign rsp.valid     = out_valid_reg;
    assign rsp.kind      = kind_reg;
    assign rsp.read_addr = raddr_reg;
    assign rsp.phys_addr = paddr_reg;
    assign rsp.page_size = size_reg;

    // base and index of the entry to ask for next
    always_comb
    begin
        if (!q_item.is_entry)
        begin
            base = root_frame;
            idx  = q_item.va_held[IDX_LSB_L4 +: INDEX_W];
        end
        else
        begin
            base = q_item.frame;
            case (level_reg)
                LEVEL_FOUR:  idx = held_reg[IDX_LSB_L3 +: INDEX_W];
                LEVEL_THREE: idx = held_reg[IDX_LSB_L2 +: INDEX_W];
                default:     idx = held_reg[IDX_LSB_L1 +: INDEX_W];
            endcase
        end
    end

    always_comb
    begin
        level_next = level_reg;
        held_next  = held_reg;
        kind_next  = KIND_PROTOCOL;
        raddr_next = '0;
        paddr_next = '0;
        size_next  = SIZE_4K;
        if (!q_item.is_entry)
        begin
            if (busy)
            begin
                kind_next = KIND_PROTOCOL;
            end
            else if (!q_item.canonical)
            begin
                kind_next  = KIND_NONCANON;
                level_next = LEVEL_IDLE;
            end
            else
            begin
                kind_next  = KIND_READ;
                held_next  = q_item.va_held;
                level_next = LEVEL_FOUR;
                raddr_next = ADDR_FIELD_W'(entry_pa);
            end
        end
        else if (!busy)
        begin
            kind_next  = KIND_PROTOCOL;
            level_next = LEVEL_IDLE;
        end
        else if (!q_item.present)
        begin
            kind_next  = KIND_ABSENT;
            level_next = LEVEL_IDLE;
        end
        else if (level_reg == LEVEL_THREE && q_item.huge)
        begin
            kind_next  = KIND_DONE;
            level_next = LEVEL_IDLE;
            paddr_next = ADDR_FIELD_W'(page_1g);
            size_next  = SIZE_1G;
        end
        else if (level_reg == LEVEL_TWO && q_item.huge)
        begin
            kind_next  = KIND_DONE;
            level_next = LEVEL_IDLE;
            paddr_next = ADDR_FIELD_W'(page_2m);
            size_next  = SIZE_2M;
        end
        else if (level_reg == LEVEL_ONE)
        begin
            kind_next  = KIND_DONE;
            level_next = LEVEL_IDLE;
            paddr_next = ADDR_FIELD_W'(page_4k);
            size_next  = SIZE_4K;
        end
        else
        begin
            kind_next  = KIND_READ;
            level_next = level_reg - 1'b1;
            raddr_next = ADDR_FIELD_W'(entry_pa);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= LEVEL_IDLE;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                level_reg     <= level_next;
                held_reg      <= held_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            kind_reg  <= kind_next;
            raddr_reg <= raddr_next;
            paddr_reg <= paddr_next;
            size_reg  <= size_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/four_level_page_walk.sv
// ----------------------------------------------------------------------------
// four_level_page_walk
// four-level page-table walker: canonical check, entry reads, translation
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake     payload
//  -------  ---  ------------  ---------------------------------------------
//  cfg      in   valid/ready   table_root (52)
//  req      in   valid/ready   mode (1), virt_addr (64), entry_data (64)
//  rsp      out  valid/ready   kind (3), read_addr (52), phys_addr (52),
//                              page_size (2)
//
//  every req beat gives exactly one rsp beat, held first in the queue slot
//  and then in the registered rsp beat; one beat per cycle is sustained
//  while rsp is ready; the rate is set by the back end, which updates the
//  walk level and held address once per beat
//  a two-entry queue between front and back keeps req ready during an
//  rsp stall; req ready drops only once the queue is full
//  reset clears the walk level, the held address, table_root and the queue
//
`default_nettype none

module four_level_page_walk (
    input  wire logic clk,
    input  wire logic rst_n,
    fwp_cfg_if.sink   cfg,
    fwp_req_if.sink   req,
    fwp_rsp_if.source rsp
);
    import fwp_pkg::*;

    // root table register, only its frame bits matter
    logic [ADDR_FIELD_W-1:0] table_root_reg;

    // front to queue
    item_t front_item;
    logic  front_push;
    logic  q_full;

    // queue to back
    item_t head_item;
    logic  q_not_empty;
    logic  q_pop;

    // config channel is always ready; the user must write only while idle, the block itself does not enforce it
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_root_reg <= '0;
        end
        else if (cfg.valid)
        begin
            table_root_reg <= cfg.table_root;
        end
    end

    // front end: takes the req beat and classifies it
    fwp_front u_front (
        .req    (req),
        .q_full (q_full),
        .q_item (front_item),
        .q_push (front_push)
    );

    // decoupling queue
    fwp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    // back end: walk state and the registered rsp beat
    fwp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .root_frame (table_root_reg[PHYS_ADDR_BITS-1:PAGE_OFF_W]),
        .q_valid    (q_not_empty),
        .q_item     (head_item),
        .q_pop      (q_pop),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire
